### design/pnrs_pkg.sv
// Package: shared types, constants and codes for the packet number range set.
`default_nettype none
package pnrs_pkg;
  localparam int MaxRanges  = 16;
  localparam int CountLimit = 255;
  localparam int HeldW      = $clog2(MaxRanges + 1);
  localparam int CmpW       = (HeldW > 5) ? HeldW : 5;

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActQuery  = 2'd1;
  localparam logic [1:0] ActRead   = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] packet_number;
    logic [4:0]  range_index;
  } in_item_t;

  typedef struct packed {
    logic        count_overflow;
    logic        is_member;
    logic        range_present;
    logic [31:0] range_lowest;
    logic [31:0] range_highest;
    logic [31:0] highest_seen;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic evaluate;
    logic apply;
  } pnrs_cmd_t;
endpackage
`default_nettype wire

### design/pnrs_ctrl.sv
// Controller: sequences capture, evaluate and apply, and owns the result valid flag.
`default_nettype none
module pnrs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pnrs_pkg::pnrs_cmd_t    cmd_o
);
  import pnrs_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StEval  = 2'd1;
  localparam logic [1:0] StApply = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.evaluate = 1'b0;
    cmd_o.apply    = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StEval;
        end
      end
      StEval: begin
        cmd_o.evaluate = 1'b1;
        state_d        = StApply;
      end
      StApply: begin
        // hold while the previous result still waits
        if (slot_free) begin
          cmd_o.apply = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.apply) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

### design/pnrs_dp.sv
// Datapath: range store, per-entry compare flags, update logic and result register.
`default_nettype none
module pnrs_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pnrs_pkg::pnrs_cmd_t cmd_i,
  input  wire pnrs_pkg::in_item_t  in_item_i,
  output pnrs_pkg::out_item_t      out_item_o
);
  import pnrs_pkg::*;

  logic [31:0]      lo_q [MaxRanges];
  logic [31:0]      lo_d [MaxRanges];
  logic [7:0]       cnt_q [MaxRanges];
  logic [7:0]       cnt_d [MaxRanges];
  logic [HeldW-1:0] held_q, held_d;
  in_item_t         item_q;
  out_item_t        res_q, res_d;

  logic [MaxRanges-1:0] abv_q, bel_q, joi_q, exh_q, inr_q;
  logic [MaxRanges-1:0] abv_d, bel_d, joi_d, exh_d, inr_d;
  logic [MaxRanges-1:0] vld;
  logic [32:0]          hi33 [MaxRanges];
  logic [32:0]          p33;

  // per-entry compares against the held item
  always_comb begin
    p33 = {1'b0, item_q.packet_number};
    for (int k = 0; k < MaxRanges; k++) begin
      vld[k]  = (CmpW'(k) < CmpW'(held_q));
      hi33[k] = {1'b0, lo_q[k]} + {25'b0, cnt_q[k]} - 33'd1;
    end
    for (int k = 0; k < MaxRanges; k++) begin
      abv_d[k] = vld[k] && (p33 > hi33[k] + 33'd1);
      bel_d[k] = vld[k] && (p33 + 33'd1 == {1'b0, lo_q[k]});
      exh_d[k] = vld[k] && (p33 == hi33[k] + 33'd1);
      inr_d[k] = vld[k] && (p33 >= {1'b0, lo_q[k]}) && (p33 <= hi33[k]);
      if (k < MaxRanges - 1) begin
        joi_d[k] = bel_d[k] && vld[(k+1)%MaxRanges] &&
                   ({1'b0, lo_q[k]} == hi33[(k+1)%MaxRanges] + 33'd2);
      end else begin
        joi_d[k] = 1'b0;
      end
    end
  end

  logic [MaxRanges-1:0] hit, sel, after;
  logic                 seen, any_hit, s_abv, s_bel, s_joi, s_exh;
  logic [7:0]           s_cnt, s_cnt_nx;
  logic [8:0]           merged;
  logic                 ovf, do_open, do_join, do_dec, do_inc, full;
  logic [MaxRanges-1:0] open_sel, open_after;
  logic [32:0]          top33;
  logic [32:0]          rd_hi;
  logic [31:0]          rd_lo;
  logic [7:0]           rd_cnt;
  logic                 rd_pres;

  always_comb begin
    hit  = abv_q | bel_q | exh_q | inr_q;
    seen = 1'b0;
    s_cnt = '0;
    s_cnt_nx = '0;
    for (int k = 0; k < MaxRanges; k++) begin
      after[k] = seen;
      sel[k]   = hit[k] && !seen;
      seen     = seen | hit[k];
      if (sel[k]) s_cnt = s_cnt | cnt_q[k];
      if (sel[k] && k < MaxRanges - 1) s_cnt_nx = s_cnt_nx | cnt_q[(k+1)%MaxRanges];
    end
    any_hit = seen;
    s_abv = |(sel & abv_q);
    s_bel = |(sel & bel_q);
    s_joi = |(sel & joi_q);
    s_exh = |(sel & exh_q);
    merged = {1'b0, s_cnt} + {1'b0, s_cnt_nx} + 9'd1;
    full   = (CmpW'(held_q) == CmpW'(MaxRanges));

    ovf = 1'b0;
    do_open = 1'b0; do_join = 1'b0; do_dec = 1'b0; do_inc = 1'b0;
    if (item_q.action == ActInsert) begin
      if (!any_hit) begin
        do_open = !full;
      end else if (s_abv) begin
        do_open = 1'b1;
      end else if (s_joi) begin
        if (merged > 9'(CountLimit)) ovf = 1'b1;
        else do_join = 1'b1;
      end else if (s_bel) begin
        if (s_cnt >= 8'(CountLimit)) ovf = 1'b1;
        else do_dec = 1'b1;
      end else if (s_exh) begin
        if (s_cnt >= 8'(CountLimit)) ovf = 1'b1;
        else do_inc = 1'b1;
      end
    end

    // append at the tail when nothing matched, else open at the matched slot
    for (int k = 0; k < MaxRanges; k++) begin
      open_sel[k]   = any_hit ? sel[k] : (CmpW'(k) == CmpW'(held_q));
      open_after[k] = any_hit ? after[k] : 1'b0;
    end

    held_d = held_q;
    for (int k = 0; k < MaxRanges; k++) begin
      lo_d[k]  = lo_q[k];
      cnt_d[k] = cnt_q[k];
    end
    if (do_open) begin
      held_d = (full ? HeldW'(MaxRanges - 1) : held_q) + HeldW'(1);
      for (int k = 0; k < MaxRanges; k++) begin
        if (open_sel[k]) begin
          lo_d[k]  = item_q.packet_number;
          cnt_d[k] = 8'd1;
        end else if (open_after[k] && k > 0) begin
          lo_d[k]  = lo_q[(k+MaxRanges-1)%MaxRanges];
          cnt_d[k] = cnt_q[(k+MaxRanges-1)%MaxRanges];
        end
      end
    end else if (do_join) begin
      held_d = held_q - HeldW'(1);
      for (int k = 0; k < MaxRanges - 1; k++) begin
        if (sel[k] || after[k]) begin
          lo_d[k]  = lo_q[k+1];
          cnt_d[k] = after[k] ? cnt_q[k+1] : merged[7:0];
        end
      end
    end else if (do_dec || do_inc) begin
      for (int k = 0; k < MaxRanges; k++) begin
        if (sel[k]) begin
          lo_d[k]  = do_dec ? lo_q[k] - 32'd1 : lo_q[k];
          cnt_d[k] = cnt_q[k] + 8'd1;
        end
      end
    end

    rd_pres = (CmpW'(item_q.range_index) < CmpW'(held_q));
    rd_lo   = lo_q[item_q.range_index[$clog2(MaxRanges)-1:0]];
    rd_cnt  = cnt_q[item_q.range_index[$clog2(MaxRanges)-1:0]];
    rd_hi   = {1'b0, rd_lo} + {25'b0, rd_cnt} - 33'd1;
    top33   = {1'b0, lo_d[0]} + {25'b0, cnt_d[0]} - 33'd1;

    res_d = '0;
    res_d.count_overflow = ovf;
    res_d.is_member      = (item_q.action == ActQuery) && (|inr_q);
    if (item_q.action == ActRead && rd_pres) begin
      res_d.range_present = 1'b1;
      res_d.range_lowest  = rd_lo;
      res_d.range_highest = rd_hi[31:0];
    end
    res_d.highest_seen = (held_d != '0) ? top33[31:0] : 32'd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_item_i;
    if (cmd_i.evaluate) begin
      abv_q <= abv_d;
      bel_q <= bel_d;
      joi_q <= joi_d;
      exh_q <= exh_d;
      inr_q <= inr_d;
    end
    if (cmd_i.apply) begin
      res_q <= res_d;
      for (int k = 0; k < MaxRanges; k++) begin
        lo_q[k]  <= lo_d[k];
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (cmd_i.apply) begin
      held_q <= held_d;
    end
  end

  assign out_item_o = res_q;
endmodule
`default_nettype wire

### design/packet_number_range_set.sv
// Top level: bounded, sorted set of received packet number ranges.
// Holds up to sixteen disjoint ranges (low end plus a run length of 1..255),
// position 0 being the highest. Each input item is an insert, a membership
// query or a read by position, and gives exactly one result item. An item
// passes from acceptance to its result through a capture step, a compare step
// in which every stored range is compared against the number in parallel and
// the flags are registered, and an update step in which the first matching
// range is picked and the store is shifted, extended or joined. The result
// waits in an output register, and the update step waits while the previous
// result is still unread; a new item is taken only once the previous one has
// passed its update step. After reset the store is empty; no clearing pass is
// needed.
`default_nettype none
module packet_number_range_set (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pnrs_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output pnrs_pkg::out_item_t      out_item_o
);
  import pnrs_pkg::*;

  pnrs_cmd_t cmd;

  // sequence each item through capture, compare and update
  pnrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // hold the ranges and form the result
  pnrs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while a previous item is in flight");

  a_valid_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.apply))
    else $error("result valid without an update cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd.apply)
    else $error("pending result overwritten");
`endif
endmodule
`default_nettype wire

### bench/pnrs_checker.sv
// Checker: watches both channels, predicts each result of the range set and compares.
module pnrs_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire pnrs_pkg::in_item_t  in_item_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire pnrs_pkg::out_item_t out_item_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  import pnrs_pkg::*;

  logic [31:0] lows [MaxRanges];
  logic [7:0]  runs [MaxRanges];
  int          held;
  out_item_t   awaited_q[$];

  function automatic logic [32:0] top_end(int i);
    return {1'b0, lows[i]} + 33'(runs[i]) - 33'd1;
  endfunction

  // open a one-element range at pos, evicting the lowest range when full
  function automatic void open_range(int pos, logic [31:0] p);
    if (held >= MaxRanges) held = MaxRanges - 1;
    if (pos > held) pos = held;
    for (int k = held; k > pos; k--) begin
      lows[k] = lows[k-1];
      runs[k] = runs[k-1];
    end
    lows[pos] = p;
    runs[pos] = 8'd1;
    held++;
  endfunction

  function automatic logic insert_number(logic [31:0] p);
    logic [32:0] pv, lo, hi;
    int merged;
    pv = {1'b0, p};
    for (int i = 0; i < held; i++) begin
      lo = {1'b0, lows[i]};
      hi = top_end(i);
      if (pv > hi + 33'd1) begin
        open_range(i, p);
        return 1'b0;
      end
      if (pv + 33'd1 == lo) begin
        if (i + 1 < held && lo == top_end(i+1) + 33'd2) begin
          merged = int'(runs[i]) + int'(runs[i+1]) + 1;
          if (merged > CountLimit) return 1'b1;
          lows[i] = lows[i+1];
          runs[i] = 8'(merged);
          for (int k = i + 1; k + 1 < held; k++) begin
            lows[k] = lows[k+1];
            runs[k] = runs[k+1];
          end
          held--;
        end else begin
          if (int'(runs[i]) >= CountLimit) return 1'b1;
          lows[i] = lows[i] - 32'd1;
          runs[i] = runs[i] + 8'd1;
        end
        return 1'b0;
      end
      if (pv == hi + 33'd1) begin
        if (int'(runs[i]) >= CountLimit) return 1'b1;
        runs[i] = runs[i] + 8'd1;
        return 1'b0;
      end
      if (pv >= lo && pv <= hi) return 1'b0;
    end
    if (held < MaxRanges) open_range(held, p);
    return 1'b0;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    logic [32:0] t;
    r = '0;
    case (it.action)
      ActInsert: r.count_overflow = insert_number(it.packet_number);
      ActQuery: begin
        for (int i = 0; i < held; i++)
          if ({1'b0, it.packet_number} >= {1'b0, lows[i]} &&
              {1'b0, it.packet_number} <= top_end(i)) r.is_member = 1'b1;
      end
      ActRead: begin
        if (int'(it.range_index) < held) begin
          t = top_end(int'(it.range_index));
          r.range_present = 1'b1;
          r.range_lowest  = lows[it.range_index];
          r.range_highest = t[31:0];
        end
      end
      default: ;
    endcase
    if (held > 0) begin
      t = top_end(0);
      r.highest_seen = t[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, want %h", what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      held = 0;
      awaited_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("unexpected item", 32'd0, 32'd0);
        end else begin
          want = awaited_q.pop_front();
          if (out_item_i.count_overflow !== want.count_overflow)
            report_mismatch("count_overflow", 32'(out_item_i.count_overflow),
                            32'(want.count_overflow));
          if (out_item_i.is_member !== want.is_member)
            report_mismatch("is_member", 32'(out_item_i.is_member), 32'(want.is_member));
          if (out_item_i.range_present !== want.range_present)
            report_mismatch("range_present", 32'(out_item_i.range_present),
                            32'(want.range_present));
          if (out_item_i.range_lowest !== want.range_lowest)
            report_mismatch("range_lowest", out_item_i.range_lowest, want.range_lowest);
          if (out_item_i.range_highest !== want.range_highest)
            report_mismatch("range_highest", out_item_i.range_highest, want.range_highest);
          if (out_item_i.highest_seen !== want.highest_seen)
            report_mismatch("highest_seen", out_item_i.highest_seen, want.highest_seen);
        end
      end
      if (in_valid_i && in_ready_i) awaited_q.push_back(predict_result(in_item_i));
      pending_o = awaited_q.size();
    end
  end
endmodule

### bench/tb_packet_number_range_set.sv
// Testbench top: drives items into the range set and gives the verdict.
module tb_packet_number_range_set;
  import pnrs_pkg::*;

  localparam int         CycleLimit = 200000;
  localparam logic [1:0] ActNone    = 2'd3;   // unused action code

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        cycle_count = 0;
  logic      calm = 1'b0;   // set for the last part of the run: no idling

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  packet_number_range_set u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item)
  );

  pnrs_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_item_i(out_item),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stall the result side in bursts of random length, with stall-free stretches.
  always @(posedge clk) begin
    int burst;
    if (calm || burst > 0 && !out_ready) begin
      if (!calm) burst--;
      if (calm || burst == 0) out_ready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      burst = $urandom_range(1, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one item and hold it until accepted; valid drops only for an idle gap.
  task automatic send_item(logic [1:0] act, logic [31:0] pn, logic [4:0] idx);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= '{action: act, packet_number: pn, range_index: idx};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly inserts near a moving base so ranges grow, join and evict.
  task automatic random_item(logic [31:0] base);
    int pick;
    logic [31:0] pn;
    pick = $urandom_range(0, 99);
    pn = base + 32'($urandom_range(0, 120)) - 32'd60;
    if (pick < 4) pn = $urandom;
    if (pick < 60)      send_item(ActInsert, pn, 5'($urandom));
    else if (pick < 80) send_item(ActQuery, pn, 5'($urandom));
    else if (pick < 97) send_item(ActRead, pn, 5'($urandom_range(0, 17)));
    else                send_item(ActNone, $urandom, 5'($urandom));
  endtask

  initial begin
    logic [31:0] base;
    int wait_count;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, extend, join, duplicate, limits, full store.
    send_item(ActInsert, 32'hFFFF_FFFF, 5'd0);
    send_item(ActInsert, 32'hFFFF_FFFE, 5'd0);
    send_item(ActInsert, 32'd0, 5'd0);
    send_item(ActInsert, 32'd2, 5'd0);
    send_item(ActInsert, 32'd1, 5'd0);       // join
    send_item(ActInsert, 32'd1, 5'd0);       // duplicate
    send_item(ActQuery, 32'hFFFF_FFFF, 5'd0);
    send_item(ActQuery, 32'd3, 5'd0);
    send_item(ActRead, 32'd0, 5'd0);
    send_item(ActRead, 32'd0, 5'd1);
    send_item(ActRead, 32'd0, 5'd31);
    send_item(ActNone, 32'h5555_AAAA, 5'd21);
    for (int i = 0; i < 260; i++) send_item(ActInsert, 32'd1000 + 32'(i), 5'd0);
    for (int i = 0; i < 20; i++) send_item(ActInsert, 32'd500 - 32'(3 * i), 5'd0);
    send_item(ActInsert, 32'd1500, 5'd0);      // new inner range, full store
    send_item(ActInsert, 32'd3, 5'd0);         // new lowest, full store
    for (int i = 0; i < 17; i++) send_item(ActRead, 32'd0, 5'(i));

    // Random: bursts around a drifting base.
    base = $urandom;
    for (int n = 0; n < 1540; n++) begin
      if (n % 150 == 0) base = (n % 300 == 0) ? $urandom : base + 32'd400;
      if (n == 1300) calm = 1'b1;
      random_item(base);
    end
    in_valid <= 1'b0;

    wait_count = 0;
    while (pending != 0 && wait_count < 10000) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
